>>> rtl/core/plg_pkg.sv
// Package for the power-law gamma core: pixel transaction types and
// configuration register indexes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package plg_pkg;

   localparam int CFG_W   = 14;
   localparam int CHAN_W  = 8;
   localparam int INDEX_W = 2;

   localparam logic [INDEX_W-1:0] CSR_GAIN     = 2'd0;
   localparam logic [INDEX_W-1:0] CSR_EXPONENT = 2'd1;
   localparam logic [INDEX_W-1:0] CSR_OFFSET   = 2'd2;

   localparam logic [CFG_W-1:0] CFG_RESET = 14'd100;

   typedef struct packed {
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } pixel_in_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
   } pixel_out_type;

endpackage
`default_nettype wire

>>> rtl/core/plg_channel.sv
// One color channel of the gamma pipeline: log table, exponent scaling,
// root-product power stages, gain and offset. Depends on plg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module plg_channel #(
   parameter int LOG_FRAC_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic [plg_pkg::CHAN_W-1:0]  x,
   input  wire logic [plg_pkg::CFG_W-1:0]   gain,
   input  wire logic [plg_pkg::CFG_W-1:0]   expo,
   input  wire logic [plg_pkg::CFG_W-1:0]   offs,
   output logic      [plg_pkg::CHAN_W-1:0]  y
);
   import plg_pkg::*;

   localparam int FB   = LOG_FRAC_BITS;
   localparam int LW   = FB + 3;
   localparam int NW   = CFG_W + LW + 1;
   localparam int DIVN = FB + 10;
   localparam int MW   = DIVN + 1;
   localparam int AW   = DIVN + MW;
   localparam int TW   = FB + 5;
   localparam int PW   = 31;
   localparam int GW   = CFG_W + PW;
   localparam int SW   = GW + 8;
   localparam int VW   = 23;

   localparam logic [PW-1:0] P_ONE = PW'(64'd1 << 30);
   localparam logic [NW-1:0] SAT_LIMIT = NW'(64'd3100 << FB);
   localparam longint unsigned DIV_M = ((64'd1 << (DIVN + 5)) + 64'd24) / 64'd25;
   localparam logic [MW-1:0] RECIP = MW'(DIV_M);
   localparam logic [VW-1:0] Y_LIMIT = VW'(25600);
   localparam logic [15:0]   RECIP100 = 16'd41944;

   function automatic longint unsigned log2_fixed(input longint unsigned v);
      longint unsigned k;
      longint unsigned m;
      longint unsigned frac;
      k = 0;
      frac = 0;
      for (int j = 0; j < 8; j++) begin
         if ((v >> (j + 1)) != 0) k = j + 1;
      end
      m = (v << 30) >> k;
      for (int i = 0; i < FB; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            frac = frac | 64'd1;
            m = m >> 1;
         end
      end
      return (k << FB) | frac;
   endfunction

   function automatic logic [255:0][LW-1:0] build_neg_log();
      logic [255:0][LW-1:0] tab;
      longint unsigned top;
      longint unsigned lg;
      top = log2_fixed(64'd255);
      tab[0] = '0;
      for (int v = 1; v < 256; v++) begin
         lg = log2_fixed(longint'(v));
         tab[v] = (lg > top) ? '0 : LW'(top - lg);
      end
      return tab;
   endfunction

   function automatic longint unsigned isqrt64(input longint unsigned v_in);
      longint unsigned v;
      longint unsigned res;
      longint unsigned bitv;
      v = v_in;
      res = 0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (bitv > v) bitv = bitv >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (bitv != 0) begin
            if (v >= res + bitv) begin
               v = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
      end
      return res;
   endfunction

   function automatic logic [FB:1][29:0] build_roots();
      logic [FB:1][29:0] tab;
      longint unsigned r;
      r = isqrt64(64'd1 << 59);
      tab[1] = 30'(r);
      for (int i = 2; i <= FB; i++) begin
         r = isqrt64(r << 30);
         tab[i] = 30'(r);
      end
      return tab;
   endfunction

   localparam logic [255:0][LW-1:0] NEG_LOG = build_neg_log();
   localparam logic [FB:1][29:0]    ROOTS   = build_roots();

   logic [LW-1:0]  log_ff;
   logic           zero1_ff;
   logic [NW-1:0]  n_ff;
   logic           zero2_ff;
   logic [AW-1:0]  a_ff;
   logic           sat3_ff;
   logic           zero3_ff;
   logic [TW-1:0]  t_w;

   always_ff @(posedge clock) begin
      log_ff   <= NEG_LOG[x];
      zero1_ff <= (x == '0);
      n_ff     <= NW'(expo * log_ff) + NW'(50);
      zero2_ff <= zero1_ff;
      a_ff     <= AW'(n_ff[DIVN+1:2] * RECIP);
      sat3_ff  <= (n_ff >= SAT_LIMIT);
      zero3_ff <= zero2_ff;
   end

   assign t_w = a_ff[DIVN+5 +: TW];

   logic [PW-1:0] p_ff    [1:FB];
   logic [FB-1:0] f_ff    [1:FB];
   logic [4:0]    q_ff    [1:FB];
   logic          sat_ff  [1:FB];
   logic          zero_ff [1:FB];

   for (genvar i = 1; i <= FB; i++) begin : g_root
      logic [PW-1:0]    p_prev;
      logic [FB-1:0]    f_prev;
      logic [4:0]       q_prev;
      logic             sat_prev;
      logic             zero_prev;
      logic [PW+29:0]   prod;
      logic [PW-1:0]    p_in;
      if (i == 1) begin : g_first
         assign p_prev    = P_ONE;
         assign f_prev    = t_w[FB-1:0];
         assign q_prev    = t_w[TW-1:FB];
         assign sat_prev  = sat3_ff;
         assign zero_prev = zero3_ff;
      end else begin : g_next
         assign p_prev    = p_ff[i-1];
         assign f_prev    = f_ff[i-1];
         assign q_prev    = q_ff[i-1];
         assign sat_prev  = sat_ff[i-1];
         assign zero_prev = zero_ff[i-1];
      end
      assign prod = p_prev * ROOTS[i];
      assign p_in = f_prev[FB-i] ? prod[PW+29:30] : p_prev;
      always_ff @(posedge clock) begin
         p_ff[i]    <= p_in;
         f_ff[i]    <= f_prev;
         q_ff[i]    <= q_prev;
         sat_ff[i]  <= sat_prev;
         zero_ff[i] <= zero_prev;
      end
   end

   logic [PW-1:0] pow_ff;
   logic [PW-1:0] pow_in;
   logic [GW-1:0] gp_ff;
   logic [SW-1:0] scaled;
   logic [VW-1:0] v_ff;
   logic [30:0]   quot;
   logic [7:0]    y_ff;
   logic [7:0]    y_in;

   always_comb begin
      if (zero_ff[FB]) begin
         pow_in = (expo == '0) ? P_ONE : '0;
      end else if (sat_ff[FB]) begin
         pow_in = '0;
      end else begin
         pow_in = p_ff[FB] >> q_ff[FB];
      end
   end

   assign scaled = {gp_ff, 8'd0} - SW'(gp_ff);
   assign quot   = v_ff[14:0] * RECIP100;
   assign y_in   = (v_ff >= Y_LIMIT) ? 8'd255 : quot[29:22];

   always_ff @(posedge clock) begin
      pow_ff <= pow_in;
      gp_ff  <= gain * pow_ff;
      v_ff   <= scaled[SW-1:30] + VW'(offs);
      y_ff   <= y_in;
   end

   assign y = y_ff;

endmodule
`default_nettype wire

>>> rtl/core/power_law_gamma_rgb_core.sv
// Top level of the power-law gamma core for RGB pixels: configuration
// registers, valid pipeline and three plg_channel instances. Depends on plg_pkg.
//
//   Channel   Ports                                  Handshake
//   request   start, busy, req_pixel                 accepted when start && !busy
//   result    rsp_strobe, rsp_pixel                  one-cycle strobe, no back-pressure
//   config    csr_we, csr_index, csr_wdata           written when csr_we is high
//
// One pixel transaction can enter every cycle while busy is low. The pipeline
// depth grows with LOG_FRAC_BITS through the chain of root multipliers, one per
// fraction bit of the exponent product. Reset clears the valid pipeline and
// loads 100 into every configuration register; busy is high only while reset
// is asserted. The receiver cannot stall the pipeline.
`timescale 1ns / 1ps
`default_nettype none
module power_law_gamma_rgb_core #(
   parameter int LOG_FRAC_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire plg_pkg::pixel_in_type         req_pixel,
   input  wire logic                          csr_we,
   input  wire logic [plg_pkg::INDEX_W-1:0]   csr_index,
   input  wire logic [plg_pkg::CFG_W-1:0]     csr_wdata,
   output logic                               rsp_strobe,
   output plg_pkg::pixel_out_type             rsp_pixel
);
   import plg_pkg::*;

   localparam int LAT = LOG_FRAC_BITS + 7;

   logic [CFG_W-1:0] gain_ff;
   logic [CFG_W-1:0] expo_ff;
   logic [CFG_W-1:0] offs_ff;
   logic [LAT-1:0]   vld_ff;
   logic [LAT-1:0]   vld_in;
   logic             accept;

   assign busy   = reset;
   assign accept = start && !busy;
   assign vld_in = {vld_ff[LAT-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= CFG_RESET;
         expo_ff <= CFG_RESET;
         offs_ff <= CFG_RESET;
         vld_ff  <= '0;
      end else begin
         vld_ff <= vld_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_GAIN:     gain_ff <= csr_wdata;
               CSR_EXPONENT: expo_ff <= csr_wdata;
               CSR_OFFSET:   offs_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   plg_channel #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_red (
      .clock(clock), .x(req_pixel.red_in), .gain(gain_ff), .expo(expo_ff),
      .offs(offs_ff), .y(rsp_pixel.red_out)
   );

   plg_channel #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_green (
      .clock(clock), .x(req_pixel.green_in), .gain(gain_ff), .expo(expo_ff),
      .offs(offs_ff), .y(rsp_pixel.green_out)
   );

   plg_channel #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_blue (
      .clock(clock), .x(req_pixel.blue_in), .gain(gain_ff), .expo(expo_ff),
      .offs(offs_ff), .y(rsp_pixel.blue_out)
   );

   assign rsp_strobe = vld_ff[LAT-1];

   a_reset_flush: assert property (@(posedge clock) reset |=> (vld_ff == '0))
      else $error("valid pipeline not cleared by reset");

   a_zero_gain: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (gain_ff == '0) && (offs_ff < CFG_W'(100))) |->
      ((rsp_pixel.red_out == '0) && (rsp_pixel.green_out == '0)
       && (rsp_pixel.blue_out == '0)))
      else $error("nonzero result with zero gain and offset below one");

   a_offset_floor: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (offs_ff >= CFG_W'(12800))) |->
      (rsp_pixel.red_out >= 8'd128))
      else $error("red result below the floor set by the offset");

endmodule
`default_nettype wire

>>> sim/power_law_gamma_rgb_core_test.sv
// Self-checking testbench for power_law_gamma_rgb_core: directed and random pixel
// transactions, checked channel by channel against stored results or a
// fixed-point gamma predictor. Depends on plg_pkg and the RTL of the core.
`timescale 1ns / 1ps
module power_law_gamma_rgb_core_test;
   import plg_pkg::*;

   localparam int FRAC = 16;
   localparam int LATENCY = FRAC + 7;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam longint unsigned ONE_Q30 = 64'd1 << 30;
   localparam logic [INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      pixel_in_type pix;
      logic [CFG_W-1:0] gain;
      logic [CFG_W-1:0] expo;
      logic [CFG_W-1:0] offs;
      bit known;
      pixel_out_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   pixel_in_type req_pixel = '0;
   logic csr_we = 1'b0;
   logic [INDEX_W-1:0] csr_index = CSR_GAIN;
   logic [CFG_W-1:0] csr_wdata = '0;
   logic rsp_strobe;
   pixel_out_type rsp_pixel;

   longint unsigned dist_log[256];
   longint unsigned root_q30[FRAC+1];
   logic [CFG_W-1:0] gain_reg = CFG_RESET;
   logic [CFG_W-1:0] expo_reg = CFG_RESET;
   logic [CFG_W-1:0] offs_reg = CFG_RESET;

   pixel_out_type pending_pixels[$];
   int errors = 0;
   int sent = 0;
   int received = 0;
   int idle_count = 0;
   stim_row_type rows[$];

   power_law_gamma_rgb_core #(.LOG_FRAC_BITS(FRAC)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_pixel(req_pixel), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .rsp_strobe(rsp_strobe), .rsp_pixel(rsp_pixel)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned fixed_log2(longint unsigned y);
      longint unsigned k;
      longint unsigned m;
      longint unsigned fr;
      k = 0;
      fr = 0;
      while ((y >> (k + 1)) != 0) k++;
      m = (y << 30) >> k;
      for (int i = 0; i < FRAC; i++) begin
         m = (m * m) >> 30;
         fr <<= 1;
         if (m >= (ONE_Q30 << 1)) begin
            fr |= 1;
            m >>= 1;
         end
      end
      return (k << FRAC) | fr;
   endfunction

   function automatic logic [CHAN_W-1:0] gamma_channel(logic [CHAN_W-1:0] x);
      longint unsigned t;
      longint unsigned q;
      longint unsigned p;
      longint unsigned y;
      p = ONE_Q30;
      if (x == 0) begin
         p = (expo_reg == 0) ? ONE_Q30 : 0;
      end else begin
         t = (64'(expo_reg) * dist_log[x] + 50) / 100;
         q = t >> FRAC;
         if (q >= 31) begin
            p = 0;
         end else begin
            for (int i = 1; i <= FRAC; i++)
               if ((t >> (FRAC - i)) & 1) p = (p * root_q30[i]) >> 30;
            p = p >> q;
         end
      end
      y = (64'(gain_reg) * 255 * p + 64'(offs_reg) * ONE_Q30) / (100 * ONE_Q30);
      return (y > 255) ? 8'd255 : y[7:0];
   endfunction

   function automatic pixel_out_type gamma_pixel(pixel_in_type pix);
      pixel_out_type r;
      r.red_out = gamma_channel(pix.red_in);
      r.green_out = gamma_channel(pix.green_in);
      r.blue_out = gamma_channel(pix.blue_in);
      return r;
   endfunction

   task automatic write_csr(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_GAIN: gain_reg = val;
         CSR_EXPONENT: expo_reg = val;
         CSR_OFFSET: offs_reg = val;
         default: ;
      endcase
   endtask

   task automatic drain_pipeline();
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic set_config(logic [CFG_W-1:0] g, logic [CFG_W-1:0] e,
                             logic [CFG_W-1:0] o);
      drain_pipeline();
      write_csr(CSR_GAIN, g);
      write_csr(CSR_EXPONENT, e);
      write_csr(CSR_OFFSET, o);
      write_csr(CSR_UNUSED, CFG_W'($urandom));
   endtask

   // Drives one transaction; start stays high across back-to-back items.
   task automatic send_pixel(pixel_in_type pix, bit known, pixel_out_type want,
                             bit may_idle);
      while (may_idle && $urandom_range(99) < 28) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_pixel <= pix;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_pixels.push_back(known ? want : gamma_pixel(pix));
      sent++;
      @(negedge clock);
   endtask

   function automatic pixel_in_type random_pixel();
      pixel_in_type p;
      p = 24'($urandom);
      if ($urandom_range(9) == 0) p.red_in = $urandom_range(1) ? 8'd255 : 8'd0;
      if ($urandom_range(9) == 0) p.blue_in = 8'($urandom_range(3));
      return p;
   endfunction

   function automatic logic [CFG_W-1:0] random_reg();
      case ($urandom_range(5))
         0: return 14'd0;
         1: return 14'd9999;
         2: return CFG_W'($urandom);
         default: return CFG_W'($urandom_range(400));
      endcase
   endfunction

   always @(posedge clock) begin
      pixel_out_type want;
      if (reset) begin
         idle_count <= 0;
      end else begin
         if ((start && !busy) || rsp_strobe) idle_count <= 0;
         else idle_count <= idle_count + 1;
         if (idle_count >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog expired with %0d transactions pending", $time,
                     pending_pixels.size());
            $display("[FAIL] regression broken");
            $finish;
         end
         if (rsp_strobe) begin
            received++;
            if (pending_pixels.size() == 0) begin
               $display("%0t unexpected transaction %h", $time, rsp_pixel);
               errors++;
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_pixel.red_out !== want.red_out)
                  $display("%0t red expected %0d actual %0d", $time, want.red_out,
                           rsp_pixel.red_out);
               if (rsp_pixel.green_out !== want.green_out)
                  $display("%0t green expected %0d actual %0d", $time,
                           want.green_out, rsp_pixel.green_out);
               if (rsp_pixel.blue_out !== want.blue_out)
                  $display("%0t blue expected %0d actual %0d", $time, want.blue_out,
                           rsp_pixel.blue_out);
               if (rsp_pixel !== want) errors++;
            end
         end
      end
   end

   initial begin
      longint unsigned top;
      longint unsigned lg;
      stim_row_type r;
      pixel_out_type none;
      int phase;
      none = '0;
      top = fixed_log2(255);
      dist_log[0] = 0;
      for (int x = 1; x < 256; x++) begin
         lg = fixed_log2(x);
         dist_log[x] = (lg > top) ? 0 : top - lg;
      end
      root_q30[0] = ONE_Q30;
      root_q30[1] = int_sqrt(64'd1 << 59);
      for (int i = 2; i <= FRAC; i++) root_q30[i] = int_sqrt(root_q30[i-1] << 30);

      // Directed rows: known results are exact at the extremes.
      rows.push_back('{'{8'd0, 8'd255, 8'd255}, 14'd100, 14'd100, 14'd100, 1'b1,
                       '{8'd1, 8'd255, 8'd255}});
      rows.push_back('{'{8'd255, 8'd255, 8'd255}, 14'd0, 14'd0, 14'd0, 1'b1,
                       '{8'd0, 8'd0, 8'd0}});
      rows.push_back('{'{8'd0, 8'd0, 8'd0}, 14'd100, 14'd0, 14'd0, 1'b1,
                       '{8'd255, 8'd255, 8'd255}});
      rows.push_back('{'{8'd0, 8'd128, 8'd255}, 14'd9999, 14'd9999, 14'd9999, 1'b1,
                       '{8'd99, 8'd99, 8'd255}});
      rows.push_back('{'{8'd0, 8'd0, 8'd0}, 14'd16383, 14'd16383, 14'd16383, 1'b1,
                       '{8'd163, 8'd163, 8'd163}});
      rows.push_back('{'{8'd10, 8'd200, 8'd1}, 14'd100, 14'd220, 14'd0, 1'b0, none});
      rows.push_back('{'{8'd64, 8'd127, 8'd254}, 14'd150, 14'd45, 14'd250, 1'b0, none});
      rows.push_back('{'{8'd1, 8'd2, 8'd3}, 14'd100, 14'd1, 14'd0, 1'b0, none});
      rows.push_back('{'{8'd170, 8'd85, 8'd85}, 14'd9999, 14'd100, 14'd0, 1'b0, none});
      rows.push_back('{'{8'd255, 8'd0, 8'd128}, 14'd0, 14'd9999, 14'd9999, 1'b0, none});
      rows.push_back('{'{8'd5, 8'd250, 8'd99}, 14'd37, 14'd3100, 14'd12, 1'b0, none});

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (rows[i]) begin
         r = rows[i];
         if (r.gain != gain_reg || r.expo != expo_reg || r.offs != offs_reg) begin
            start <= 1'b0;
            set_config(r.gain, r.expo, r.offs);
         end
         send_pixel(r.pix, r.known, r.want, 1'b0);
      end

      for (phase = 0; phase < 13; phase++) begin
         start <= 1'b0;
         set_config(random_reg(), random_reg(), random_reg());
         for (int n = 0; n < 150; n++)
            send_pixel(random_pixel(), 1'b0, none, phase != 3);
         if (phase == 6) begin
            start <= 1'b0;
            while (pending_pixels.size() != 0) @(negedge clock);
         end
      end
      start <= 1'b0;
      drain_pipeline();

      $display("Sent %0d pixel transactions over directed and 13 random register settings;",
               sent);
      $display("%0d results checked.", received);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatching transactions", errors);
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

>>> filelist.f
rtl/core/plg_pkg.sv
rtl/core/plg_channel.sv
rtl/core/power_law_gamma_rgb_core.sv
sim/power_law_gamma_rgb_core_test.sv
